FILE: design/mntd_pkg.sv
// shared constants, types and helpers for the midi note duration tracker
package mntd_pkg;

  // key store
  localparam int unsigned KEY_COUNT = 128;
  localparam int unsigned KEY_W     = $clog2(KEY_COUNT);

  // field and datapath widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned MPQ_W   = 24;
  localparam int unsigned TPQ_W   = 15;
  localparam int unsigned BPM_W   = 10;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned TIME_W  = TICK_W + FRAC_W;
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned NUM_W   = TICK_W + MPQ_W;
  localparam int unsigned MUSEC_W = 20;
  localparam int unsigned DEN_W   = TPQ_W + MUSEC_W;
  localparam int unsigned ENTRY_W = VEL_W + TIME_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TPQ_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPQ = 2'd0,
    CFG_BPM = 2'd1
  } cfg_idx_e;

  localparam logic [TPQ_W-1:0] TPQ_RESET = 15'd480;
  localparam logic [BPM_W-1:0] BPM_RESET = 10'd120;

  // status and meta codes
  localparam logic [BYTE_W-1:0] CMD_MASK     = 8'hF0;
  localparam logic [BYTE_W-1:0] CMD_NOTE_ON  = 8'h90;
  localparam logic [BYTE_W-1:0] CMD_NOTE_OFF = 8'h80;
  localparam logic [BYTE_W-1:0] STATUS_META  = 8'hFF;
  localparam logic [BYTE_W-1:0] META_TEMPO   = 8'h51;

  // time constants
  localparam logic [MPQ_W-1:0]   SECS_PER_MIN   = 24'd60;
  localparam logic [MUSEC_W-1:0] MICROS_PER_SEC = 20'd1000000;
  localparam logic [VEL_W-1:0]   VEL_MAX        = 7'd127;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WRITE,
    ST_DIFF,
    ST_FRAMES
  } st_e;

  // floor(t * 60 / 2^16), saturated to the frame width
  function automatic logic [FRAME_W-1:0] frames_of(input logic [TIME_W-1:0] t);
    logic [TIME_W+5:0] p;
    logic [TIME_W-FRAC_W+5:0] f;
    p = {t, 6'b0} - {4'b0, t, 2'b0};
    f = p[TIME_W+5:FRAC_W];
    if (|f[TIME_W-FRAC_W+5:FRAME_W]) begin
      frames_of = '1;
    end else begin
      frames_of = f[FRAME_W-1:0];
    end
  endfunction

endpackage

FILE: design/mntd_if.sv
// channel interfaces: midi events in, finished notes out, register writes
interface mntd_evt_if;
  import mntd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] data_one;
  logic [BYTE_W-1:0] data_two;
  logic [BYTE_W-1:0] tempo_high;
  logic [BYTE_W-1:0] tempo_mid;
  logic [BYTE_W-1:0] tempo_low;
  logic [TICK_W-1:0] abs_tick;
  logic              pedal_down;

  modport source (
    output valid, status_byte, data_one, data_two, tempo_high, tempo_mid,
    output tempo_low, abs_tick, pedal_down,
    input  ready
  );
  modport sink (
    input  valid, status_byte, data_one, data_two, tempo_high, tempo_mid,
    input  tempo_low, abs_tick, pedal_down,
    output ready
  );
endinterface

interface mntd_note_if;
  import mntd_pkg::*;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] start_frame;
  logic [FRAME_W-1:0] length_frames;
  logic [KEY_W-1:0]   note_key;
  logic [VEL_W-1:0]   note_velocity;
  logic               sustain_flag;

  modport source (
    output valid, start_frame, length_frames, note_key, note_velocity, sustain_flag,
    input  ready
  );
  modport sink (
    input  valid, start_frame, length_frames, note_key, note_velocity, sustain_flag,
    output ready
  );
endinterface

interface mntd_cfg_if;
  import mntd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/mntd_div.sv
// restoring divider: floor(num * 2^16 / den), saturated to all ones on overflow, one quotient bit per cycle
module mntd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mntd_pkg::NUM_W-1:0]  num_i,
  input  logic [mntd_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [mntd_pkg::TIME_W-1:0] quot_o
);
  import mntd_pkg::*;

  localparam int unsigned HI_W  = NUM_W - TICK_W;
  localparam int unsigned STEPS = TICK_W + FRAC_W;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DEN_W-1:0]   den_q;
  logic [DEN_W-1:0]   rem_q;
  logic [STEPS-1:0]   bits_q;
  logic [TIME_W-1:0]  quo_q;

  logic [HI_W-1:0]    num_hi;
  logic               ovf;
  logic [DEN_W:0]     trial;
  logic [DEN_W:0]     diff;
  logic               take;

  // quotient reaches 2^48 exactly when the upper numerator part is >= den
  assign num_hi = num_i[NUM_W-1 -: HI_W];
  assign ovf    = DEN_W'(num_hi) >= den_i;
  assign trial  = {rem_q, bits_q[STEPS-1]};
  assign diff   = trial - {1'b0, den_q};
  assign take   = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      quo_q  <= ovf ? '1 : '0;
      rem_q  <= DEN_W'(num_hi);
      bits_q <= {num_i[TICK_W-1:0], FRAC_W'(0)};
    end else if (busy_q) begin
      rem_q  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q  <= {quo_q[TIME_W-2:0], take};
      bits_q <= {bits_q[STEPS-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: design/midi_note_duration_tracker.sv
// top level: pairs note-on and note-off events per key and reports note timing
//
//  channel | dir | transfer moves
//  --------+-----+----------------------------------------------------------
//  evt_i   | in  | one midi event: status, data bytes, tempo bytes, tick, pedal
//  note_o  | out | one finished note: start frame, length, key, velocity, pedal
//  cfg_i   | in  | one register write: index and data (always ready)
//
//  an event that changes nothing or only the tempo goes back to idle after decode;
//  one that needs a time also runs both multiplies, the 48-step shared divider
//  and a write or a difference and frame step; one event is in flight at a time
//  a time past the 48-bit range saturates at once, the divider skipping its steps
//  reset clears the key valid bits, tempo and registers at once; no sweep
//  a stalled note output holds the block in its last step until the transfer
module midi_note_duration_tracker (
  input logic         clk_i,
  input logic         rst_ni,
  mntd_evt_if.sink    evt_i,
  mntd_note_if.source note_o,
  mntd_cfg_if.sink    cfg_i
);
  import mntd_pkg::*;

  // configuration and tempo state
  logic [TPQ_W-1:0]   tpq_q;
  logic [BPM_W-1:0]   bpm_q;
  logic               tempo_taken_q;
  logic [MPQ_W-1:0]   mpq_q;

  // captured event
  logic [BYTE_W-1:0]  status_q;
  logic [BYTE_W-1:0]  d1_q;
  logic [BYTE_W-1:0]  d2_q;
  logic [MPQ_W-1:0]   tempo_q;
  logic [TICK_W-1:0]  tick_q;
  logic               pedal_q;

  // arithmetic
  logic [NUM_W-1:0]   num_q;
  logic [DEN_W-1:0]   den_q;
  logic [TIME_W-1:0]  t_q;
  logic [TIME_W-1:0]  diff_q;
  logic               div_done;
  logic [TIME_W-1:0]  div_quot;

  // key store: {velocity, start time}; a key is active when its valid bit is set
  logic [ENTRY_W-1:0] mem_q [KEY_COUNT];
  logic [ENTRY_W-1:0] rd_q;
  logic [KEY_COUNT-1:0] act_q;

  // output register
  logic               out_valid_q;
  logic [FRAME_W-1:0] out_start_q;
  logic [FRAME_W-1:0] out_len_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [VEL_W-1:0]   out_vel_q;
  logic               out_sus_q;

  st_e state_q, state_d;

  // control outputs of the sequencer
  logic evt_ready;
  logic tempo_load;
  logic mem_rd_en;
  logic mul_num_en;
  logic mul_den_en;
  logic div_start;
  logic mem_wr_en;
  logic diff_en;
  logic out_load;

  // event decode, from the captured fields
  logic [BYTE_W-1:0]  cmd;
  logic               is_tempo;
  logic               is_note;
  logic               key_ok;
  logic               is_on_start;
  logic [KEY_W-1:0]   key;
  logic               key_active;
  logic               needs_time;
  logic               out_free;
  logic [VEL_W-1:0]   vel_sat;

  // time scaling operands
  logic [TPQ_W-1:0]   tpq_eff;
  logic [BPM_W-1:0]   bpm_eff;
  logic [MPQ_W-1:0]   num_factor;
  logic [MUSEC_W-1:0] den_factor;
  logic [TIME_W-1:0]  t_on;

  assign cmd         = status_q & CMD_MASK;
  assign is_tempo    = (status_q == STATUS_META) && (d1_q == META_TEMPO) && !tempo_taken_q;
  assign is_note     = (cmd == CMD_NOTE_ON) || (cmd == CMD_NOTE_OFF);
  assign key_ok      = d1_q < BYTE_W'(KEY_COUNT);
  assign is_on_start = (cmd == CMD_NOTE_ON) && (d2_q != '0);
  assign key         = d1_q[KEY_W-1:0];
  assign key_active  = act_q[key];
  // note-on stores a time; note-off on an active key ends the note
  assign needs_time  = is_note && key_ok && (is_on_start || key_active);
  assign out_free    = !out_valid_q || note_o.ready;
  assign vel_sat     = d2_q[BYTE_W-1] ? VEL_MAX : d2_q[VEL_W-1:0];

  // zero registers count as one
  assign tpq_eff    = (tpq_q == '0) ? TPQ_W'(1) : tpq_q;
  assign bpm_eff    = (bpm_q == '0) ? BPM_W'(1) : bpm_q;
  assign num_factor = tempo_taken_q ? mpq_q : SECS_PER_MIN;
  assign den_factor = tempo_taken_q ? MICROS_PER_SEC : MUSEC_W'(bpm_eff);
  assign t_on       = rd_q[TIME_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (evt_i.valid) state_d = ST_DECODE;
      ST_DECODE:    state_d = needs_time ? ST_MUL_NUM : ST_IDLE;
      ST_MUL_NUM:   state_d = ST_MUL_DEN;
      ST_MUL_DEN:   state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_d = is_on_start ? ST_WRITE : ST_DIFF;
      end
      ST_WRITE:     state_d = ST_IDLE;
      ST_DIFF:      state_d = ST_FRAMES;
      ST_FRAMES:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    evt_ready  = 1'b0;
    tempo_load = 1'b0;
    mem_rd_en  = 1'b0;
    mul_num_en = 1'b0;
    mul_den_en = 1'b0;
    div_start  = 1'b0;
    mem_wr_en  = 1'b0;
    diff_en    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:      evt_ready = 1'b1;
      ST_DECODE: begin
        tempo_load = is_tempo;
        // start time of the ending note comes back in the next cycle
        mem_rd_en  = needs_time && !is_on_start;
      end
      ST_MUL_NUM:   mul_num_en = 1'b1;
      ST_MUL_DEN:   mul_den_en = 1'b1;
      ST_DIV_START: div_start  = 1'b1;
      ST_DIV_WAIT:  ;
      ST_WRITE:     mem_wr_en  = 1'b1;
      ST_DIFF:      diff_en    = 1'b1;
      ST_FRAMES:    out_load   = out_free;
      default:      ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpq_q <= TPQ_RESET;
      bpm_q <= BPM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_TPQ: tpq_q <= cfg_i.data[TPQ_W-1:0];
        CFG_BPM: bpm_q <= cfg_i.data[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // first tempo event wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_taken_q <= 1'b0;
      mpq_q         <= '0;
    end else if (tempo_load) begin
      tempo_taken_q <= 1'b1;
      mpq_q         <= tempo_q;
    end
  end

  // event capture and arithmetic operands
  always_ff @(posedge clk_i) begin
    if (evt_ready && evt_i.valid) begin
      status_q <= evt_i.status_byte;
      d1_q     <= evt_i.data_one;
      d2_q     <= evt_i.data_two;
      tempo_q  <= {evt_i.tempo_high, evt_i.tempo_mid, evt_i.tempo_low};
      tick_q   <= evt_i.abs_tick;
      pedal_q  <= evt_i.pedal_down;
    end
    // ticks times seconds-per-minute or microseconds-per-quarter
    if (mul_num_en) begin
      num_q <= NUM_W'(tick_q) * NUM_W'(num_factor);
    end
    // ticks-per-quarter times bpm or one million
    if (mul_den_en) begin
      den_q <= DEN_W'(tpq_eff) * DEN_W'(den_factor);
    end
    if (div_done) begin
      t_q <= div_quot;
    end
    // backward time gives zero length
    if (diff_en) begin
      diff_q <= (t_q > t_on) ? (t_q - t_on) : '0;
    end
  end

  mntd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // key store, one port written at note-on, read at note-off
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem_q[key] <= {vel_sat, t_q};
    end
    if (mem_rd_en) begin
      rd_q <= mem_q[key];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= '0;
    end else if (mem_wr_en) begin
      act_q[key] <= 1'b1;
    end else if (out_load) begin
      act_q[key] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (note_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_start_q <= frames_of(t_on);
      out_len_q   <= frames_of(diff_q);
      out_key_q   <= key;
      out_vel_q   <= rd_q[TIME_W +: VEL_W];
      out_sus_q   <= pedal_q;
    end
  end

  assign evt_i.ready          = evt_ready;
  assign note_o.valid         = out_valid_q;
  assign note_o.start_frame   = out_start_q;
  assign note_o.length_frames = out_len_q;
  assign note_o.note_key      = out_key_q;
  assign note_o.note_velocity = out_vel_q;
  assign note_o.sustain_flag  = out_sus_q;

endmodule

FILE: design/mntd_chk.sv
// port-level checks for the tracker, bound to the top level
module mntd_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         evt_valid_i,
  input logic                         evt_ready_i,
  input logic                         note_valid_i,
  input logic                         note_ready_i,
  input logic [mntd_pkg::FRAME_W-1:0] start_frame_i,
  input logic [mntd_pkg::FRAME_W-1:0] length_frames_i,
  input logic [mntd_pkg::KEY_W-1:0]   note_key_i,
  input logic [mntd_pkg::VEL_W-1:0]   note_velocity_i
);
  import mntd_pkg::*;

  // a pending note stays offered until taken
  a_note_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_valid_i && !note_ready_i |=> note_valid_i)
    else $error("note output dropped before transfer");

  // a pending note keeps its payload
  a_note_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_valid_i && !note_ready_i |=> $stable(start_frame_i) && $stable(length_frames_i)
      && $stable(note_key_i) && $stable(note_velocity_i))
    else $error("note payload changed while stalled");

  // one event at a time: the input is not ready in the cycle after an event transfer
  a_evt_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("event accepted while another is in flight");

  // a finished note always carries its stored nonzero velocity
  a_note_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    note_valid_i |-> note_velocity_i != '0)
    else $error("note reported with zero velocity");

endmodule

bind midi_note_duration_tracker mntd_chk u_mntd_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .evt_valid_i     (evt_i.valid),
  .evt_ready_i     (evt_i.ready),
  .note_valid_i    (note_o.valid),
  .note_ready_i    (note_o.ready),
  .start_frame_i   (note_o.start_frame),
  .length_frames_i (note_o.length_frames),
  .note_key_i      (note_o.note_key),
  .note_velocity_i (note_o.note_velocity)
);
